// ----- src/cabin_pkg.sv -----
// Shared codes for the cylindrical absorption binner.
// Result status codes, opcodes, register indexes, grid sizes and widths; no dependencies.
`default_nettype none
package cabin_pkg;

   localparam int R_BINS    = 64;
   localparam int Z_BINS    = 64;
   localparam int T_SLICES  = 16;
   localparam int ACC_WIDTH = 48;

   localparam logic [2:0] ST_RECORDED = 3'd0;
   localparam logic [2:0] ST_OUTSIDE  = 3'd1;
   localparam logic [2:0] ST_BEYOND   = 3'd2;
   localparam logic [2:0] ST_READ_OK  = 3'd3;
   localparam logic [2:0] ST_READ_BAD = 3'd4;

   localparam logic OP_RECORD = 1'b0;
   localparam logic OP_READ   = 1'b1;

   localparam logic [2:0] REG_MAX_RADIUS  = 3'd0;
   localparam logic [2:0] REG_MAX_DEPTH   = 3'd1;
   localparam logic [2:0] REG_STEP_R      = 3'd2;
   localparam logic [2:0] REG_STEP_Z      = 3'd3;
   localparam logic [2:0] REG_STEP_T      = 3'd4;
   localparam logic [2:0] REG_TIME_SLICES = 3'd5;

   localparam int REQ_DATA_W = 232;
   localparam int RSP_DATA_W = 72;

endpackage
`default_nettype wire

// ----- src/cylindrical_absorption_binner_unit.sv -----
// Cylindrical absorption binner: r/z/t grid of saturating accumulators.
// Depends on cabin_pkg.
//
// Usage: events and reads enter on the req_ stream (tuser = op: 0 record,
// 1 read), results leave on the rsp_ stream, one result per request.
// Registers must be written on the csr_ port while the block is idle; the
// block does not enforce this. A record runs a bit-serial square root and
// a shared one-bit-per-cycle restoring divider: radial bin, depth bin, and
// when step_t and velocity are nonzero time of flight and slice. A record
// makes one read-modify-write pass on the accumulator memory, and a second
// for the time slice when that slice is in range.
// One item is in flight at a time; the next request is taken while the
// previous result still waits in the output register. If the receiver
// stalls, a finished item waits until the output register frees.
// Reset starts a clearing pass over all T_SLICES*R_BINS*Z_BINS (65536)
// accumulator cells during which no request is taken; csr writes are
// still accepted.
`default_nettype none
module cylindrical_absorption_binner_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // pos_x, pos_y, pos_z, weight, t_launch, optical_path, velocity,
   // sel_slice, sel_r, sel_z
   input  wire logic [cabin_pkg::REQ_DATA_W-1:0]  req_tdata,
   // op
   input  wire logic                              req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // status, bin_value, r_bin, z_bin, time_slot, zero padding
   output logic [cabin_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input  wire logic                              csr_we,
   input  wire logic [2:0]                        csr_addr,
   input  wire logic [31:0]                       csr_wdata
);
   import cabin_pkg::*;

   localparam int GRID  = R_BINS * Z_BINS;
   localparam int DEPTH = T_SLICES * GRID;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int RW    = (R_BINS > 1) ? $clog2(R_BINS) : 1;
   localparam int ZW    = (Z_BINS > 1) ? $clog2(Z_BINS) : 1;

   localparam logic [3:0] S_CLR   = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_SQX   = 4'd2;
   localparam logic [3:0] S_SQY   = 4'd3;
   localparam logic [3:0] S_ADD   = 4'd4;
   localparam logic [3:0] S_SQRT  = 4'd5;
   localparam logic [3:0] S_CHK   = 4'd6;
   localparam logic [3:0] S_DIV   = 4'd7;
   localparam logic [3:0] S_POST  = 4'd8;
   localparam logic [3:0] S_MRD   = 4'd9;
   localparam logic [3:0] S_MWR   = 4'd10;
   localparam logic [3:0] S_RADDR = 4'd11;
   localparam logic [3:0] S_DONE  = 4'd12;

   localparam logic [1:0] PH_R = 2'd0;
   localparam logic [1:0] PH_Z = 2'd1;
   localparam logic [1:0] PH_T = 2'd2;
   localparam logic [1:0] PH_K = 2'd3;

   // configuration
   logic [31:0] max_radius_ff, max_depth_ff, step_r_ff, step_z_ff, step_t_ff;
   logic [4:0]  tsu_ff;

   logic [3:0]  state_ff, state_in;
   logic [AW-1:0] addr_ff, addr_in, cell_ff, cell_in;
   logic [31:0] ax_ff, ax_in, ay_ff, ay_in, zq_ff, zq_in;
   logic        zneg_ff, zneg_in;
   logic [23:0] w_ff, w_in;
   logic [31:0] launch_ff, launch_in, path_ff, path_in, vel_ff, vel_in;
   logic [3:0]  sels_ff, sels_in;
   logic [5:0]  selr_ff, selr_in, selz_ff, selz_in;
   logic        isread_ff, isread_in, second_ff, second_in;
   logic [63:0] sq_ff, sq_in, prod_ff, prod_in;
   logic [33:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [48:0] dvd_ff, dvd_in, quo_ff, quo_in, ir_ff, ir_in;
   logic [31:0] dvr_ff, dvr_in, drem_ff, drem_in;
   logic [1:0]  phase_ff, phase_in;
   logic [2:0]  stat_ff, stat_in;
   logic [47:0] val_ff, val_in;
   logic [5:0]  rb_ff, rb_in, zb_ff, zb_in;
   logic [3:0]  ts_ff, ts_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // accumulator memory
   logic [ACC_WIDTH-1:0] mem [DEPTH];
   logic [ACC_WIDTH-1:0] rdata_ff;
   logic                 mem_we;
   logic [ACC_WIDTH-1:0] mem_wdata;

   // datapath steps
   logic [35:0] s_rs, s_trial;
   logic        s_ge;
   logic [32:0] d_sh;
   logic        d_ge;
   logic [31:0] d_rem;
   logic [ACC_WIDTH:0] asum;
   logic [48:0] tsum;
   logic [49:0] kval;
   logic [31:0] used;
   logic        accept;

   assign s_rs    = {rem_ff, sq_ff[63:62]};
   assign s_trial = {2'b00, root_ff, 2'b01};
   assign s_ge    = (s_rs >= s_trial);
   assign d_sh    = {drem_ff, dvd_ff[48]};
   assign d_ge    = (d_sh >= {1'b0, dvr_ff});
   assign d_rem   = d_ge ? 32'(d_sh - {1'b0, dvr_ff}) : d_sh[31:0];
   assign asum    = {1'b0, rdata_ff} + (ACC_WIDTH + 1)'(w_ff);
   assign tsum    = {17'd0, launch_ff} + {1'b0, quo_ff[47:0]};
   assign kval    = {1'b0, quo_ff} + 50'd1;
   assign used    = (32'(tsu_ff) < 32'(T_SLICES)) ? 32'(tsu_ff) : 32'(T_SLICES);

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in = state_ff;   addr_in = addr_ff;     cell_in = cell_ff;
      ax_in = ax_ff;         ay_in = ay_ff;         zq_in = zq_ff;
      zneg_in = zneg_ff;     w_in = w_ff;           launch_in = launch_ff;
      path_in = path_ff;     vel_in = vel_ff;       sels_in = sels_ff;
      selr_in = selr_ff;     selz_in = selz_ff;     isread_in = isread_ff;
      second_in = second_ff; sq_in = sq_ff;         prod_in = prod_ff;
      rem_in = rem_ff;       root_in = root_ff;     cnt_in = cnt_ff;
      dvd_in = dvd_ff;       quo_in = quo_ff;       ir_in = ir_ff;
      dvr_in = dvr_ff;       drem_in = drem_ff;     phase_in = phase_ff;
      stat_in = stat_ff;     val_in = val_ff;       rb_in = rb_ff;
      zb_in = zb_ff;         ts_in = ts_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mem_we    = 1'b0;
      mem_wdata = asum[ACC_WIDTH] ? '1 : asum[ACC_WIDTH-1:0];

      unique case (state_ff)
         S_CLR: begin
            mem_we    = 1'b1;
            mem_wdata = '0;
            addr_in   = addr_ff + AW'(1);
            if (addr_ff == AW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               ax_in     = req_tdata[31] ? 32'(-req_tdata[31:0]) : req_tdata[31:0];
               ay_in     = req_tdata[63] ? 32'(-req_tdata[63:32]) : req_tdata[63:32];
               zq_in     = req_tdata[95:64];
               zneg_in   = req_tdata[95];
               w_in      = req_tdata[119:96];
               launch_in = req_tdata[151:120];
               path_in   = req_tdata[183:152];
               vel_in    = req_tdata[215:184];
               sels_in   = req_tdata[219:216];
               selr_in   = req_tdata[225:220];
               selz_in   = req_tdata[231:226];
               isread_in = (req_tuser == OP_READ);
               val_in = '0; rb_in = '0; zb_in = '0; ts_in = '0;
               state_in  = (req_tuser == OP_READ) ? S_RADDR : S_SQX;
            end
         end
         S_SQX: begin
            sq_in    = ax_ff * ax_ff;
            state_in = S_SQY;
         end
         S_SQY: begin
            prod_in  = ay_ff * ay_ff;
            state_in = S_ADD;
         end
         S_ADD: begin
            sq_in    = sq_ff + prod_ff;
            rem_in   = '0;
            root_in  = '0;
            cnt_in   = 6'd32;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            // one root bit per cycle, two radicand bits shifted in
            rem_in  = s_ge ? 34'(s_rs - s_trial) : s_rs[33:0];
            root_in = {root_ff[30:0], s_ge};
            sq_in   = {sq_ff[61:0], 2'b00};
            cnt_in  = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            if (root_ff > max_radius_ff || zneg_ff || zq_ff > max_depth_ff) begin
               stat_in  = ST_OUTSIDE;
               state_in = S_DONE;
            end else begin
               dvd_in = {root_ff, 17'd0}; dvr_in = step_r_ff;
               drem_in = '0; quo_in = '0; cnt_in = 6'd32; phase_in = PH_R;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            dvd_in  = {dvd_ff[47:0], 1'b0};
            drem_in = d_rem;
            quo_in  = {quo_ff[47:0], d_ge};
            cnt_in  = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               state_in = S_POST;
            end
         end
         S_POST: begin
            unique case (phase_ff)
               PH_R: begin
                  ir_in = quo_ff;
                  dvd_in = {zq_ff, 17'd0}; dvr_in = step_z_ff;
                  drem_in = '0; quo_in = '0; cnt_in = 6'd32; phase_in = PH_Z;
                  state_in = S_DIV;
               end
               PH_Z: begin
                  if (ir_ff >= 49'(R_BINS) || quo_ff >= 49'(Z_BINS)) begin
                     stat_in  = ST_BEYOND;
                     state_in = S_DONE;
                  end else begin
                     stat_in   = ST_RECORDED;
                     rb_in     = ir_ff[5:0];
                     zb_in     = quo_ff[5:0];
                     cell_in   = AW'(32'(ir_ff[RW-1:0]) * 32'(Z_BINS)
                                     + 32'(quo_ff[ZW-1:0]));
                     addr_in   = cell_in;
                     second_in = 1'b0;
                     state_in  = S_MRD;
                  end
               end
               PH_T: begin
                  dvd_in = tsum; dvr_in = step_t_ff;
                  drem_in = '0; quo_in = '0; cnt_in = 6'd49; phase_in = PH_K;
                  state_in = S_DIV;
               end
               PH_K: begin
                  if (kval < 50'(used)) begin
                     ts_in     = kval[3:0];
                     addr_in   = AW'(32'(kval[8:0]) * 32'(GRID) + 32'(cell_ff));
                     second_in = 1'b1;
                     state_in  = S_MRD;
                  end else begin
                     state_in = S_DONE;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_RADDR: begin
            if (32'(sels_ff) >= 32'(T_SLICES) || 32'(selr_ff) >= 32'(R_BINS)
                || 32'(selz_ff) >= 32'(Z_BINS)) begin
               stat_in  = ST_READ_BAD;
               state_in = S_DONE;
            end else begin
               stat_in  = ST_READ_OK;
               addr_in  = AW'((32'(sels_ff) * 32'(R_BINS) + 32'(selr_ff))
                              * 32'(Z_BINS) + 32'(selz_ff));
               state_in = S_MRD;
            end
         end
         S_MRD: begin
            // read data lands in rdata_ff at this edge
            state_in = S_MWR;
         end
         S_MWR: begin
            if (isread_ff) begin
               val_in   = rdata_ff;
               state_in = S_DONE;
            end else begin
               mem_we = 1'b1;
               if (!second_ff && step_t_ff != 32'd0 && vel_ff != 32'd0) begin
                  dvd_in = {path_ff, 17'd0}; dvr_in = vel_ff;
                  drem_in = '0; quo_in = '0; cnt_in = 6'd48; phase_in = PH_T;
                  state_in = S_DIV;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'd0, ts_ff, zb_ff, rb_ff, val_ff, stat_ff};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;     ax_ff <= ax_in;         ay_ff <= ay_in;
      zq_ff <= zq_in;         zneg_ff <= zneg_in;     w_ff <= w_in;
      launch_ff <= launch_in; path_ff <= path_in;     vel_ff <= vel_in;
      sels_ff <= sels_in;     selr_ff <= selr_in;     selz_ff <= selz_in;
      isread_ff <= isread_in; second_ff <= second_in; sq_ff <= sq_in;
      prod_ff <= prod_in;     rem_ff <= rem_in;       root_ff <= root_in;
      cnt_ff <= cnt_in;       dvd_ff <= dvd_in;       quo_ff <= quo_in;
      ir_ff <= ir_in;         dvr_ff <= dvr_in;       drem_ff <= drem_in;
      phase_ff <= phase_in;   stat_ff <= stat_in;     val_ff <= val_in;
      rb_ff <= rb_in;         zb_ff <= zb_in;         ts_ff <= ts_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr_ff] <= mem_wdata;
      end
      rdata_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_radius_ff <= 32'd0;
         max_depth_ff  <= 32'd0;
         step_r_ff     <= 32'd65536;
         step_z_ff     <= 32'd65536;
         step_t_ff     <= 32'd0;
         tsu_ff        <= 5'd1;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_MAX_RADIUS:  max_radius_ff <= csr_wdata;
            REG_MAX_DEPTH:   max_depth_ff  <= csr_wdata;
            REG_STEP_R:      step_r_ff     <= csr_wdata;
            REG_STEP_Z:      step_z_ff     <= csr_wdata;
            REG_STEP_T:      step_t_ff     <= csr_wdata;
            REG_TIME_SLICES: tsu_ff        <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

endmodule
`default_nettype wire

// ----- src/cabin_checker.sv -----
// Port-level checks for cylindrical_absorption_binner_unit, bound to it.
// Depends on cabin_pkg.
`default_nettype none
module cabin_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_tready,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [cabin_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import cabin_pkg::*;

   // hold a stalled result beat
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed");

   // clearing pass blocks requests after reset
   a_clr: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("request taken or result shown during clearing pass");

   a_val: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] != ST_READ_OK |-> rsp_tdata[50:3] == 48'd0)
      else $error("bin value on a non-read result");

   a_bins: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] != ST_RECORDED |-> rsp_tdata[66:51] == 16'd0)
      else $error("bin indexes on a non-record result");

   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] <= ST_READ_BAD && rsp_tdata[71:67] == 5'd0)
      else $error("bad status code or padding");

endmodule

bind cylindrical_absorption_binner_unit cabin_checker u_cabin_checker (
   .clock(clock), .reset(reset), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
`default_nettype wire
